// ----- hw/rtl/linear_resampler_core_macros.svh -----
// ---------------------------------------------------------------------------
// linear resampler assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef LINEAR_RESAMPLER_CORE_MACROS_SVH
`define LINEAR_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LRS_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lrs check failed");
`define LRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lrs check failed");
`else
`define LRS_ASSERT_IMPLIES(label, ante, cons)
`define LRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/lrs_pkg.sv -----
// ---------------------------------------------------------------------------
// lrs_pkg
// widths, register indexes and shared types of the linear resampler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 18;
   localparam int PHASE_W    = 19;
   localparam int NUM_W      = 38;
   localparam int QUOT_W     = 17;
   localparam int DIVD_W     = 36;
   localparam int REM_W      = DIVD_W - QUOT_W;
   localparam int CSR_ADDR_W = 1;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   localparam csr_addr_type REG_SOURCE_RATE = 1'b0;
   localparam csr_addr_type REG_TARGET_RATE = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hw/rtl/lrs_div.sv -----
// ---------------------------------------------------------------------------
// lrs_div
// bit-serial restoring divider, (2|num| + den) / (2 den), one quotient bit
// per cycle, result saturated to a signed sample
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrs_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [lrs_pkg::NUM_W-1:0]     num,
   input  logic        [lrs_pkg::RATE_W-1:0]    den,
   output logic signed [lrs_pkg::SAMPLE_W-1:0]  quot,
   output lrs_pkg::div_stat_type                stat
);
   import lrs_pkg::*;

   localparam int STEP_W = $clog2(QUOT_W + 1);
   localparam logic [QUOT_W-1:0] Q_LIM = QUOT_W'(2 ** (SAMPLE_W - 1));

   logic [NUM_W-1:0]  mag;
   logic [DIVD_W-1:0] dvd;
   logic [REM_W:0]    trial;
   logic              fit;
   logic              big;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dvs_ff, dvs_in;
   logic [QUOT_W-1:0] dsh_ff, dsh_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dvd   = {mag[DIVD_W-2:0], 1'b0} + DIVD_W'(den);
      trial = {rem_ff, dsh_ff[QUOT_W-1]};
      fit   = trial >= {1'b0, dvs_ff};

      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = dvd[DIVD_W-1:QUOT_W];
         dsh_in  = dvd[QUOT_W-1:0];
         dvs_in  = {den, 1'b0};
         neg_in  = num[NUM_W-1];
         q_in    = '0;
         cnt_in  = STEP_W'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fit ? REM_W'(trial - {1'b0, dvs_ff}) : trial[REM_W-1:0];
         dsh_in = {dsh_ff[QUOT_W-2:0], 1'b0};
         q_in   = {q_ff[QUOT_W-2:0], fit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // saturate to the sample range
   always_comb begin
      big = q_ff >= Q_LIM;
      if (neg_ff) begin
         quot = big ? SAMPLE_W'(Q_LIM) : SAMPLE_W'(-q_ff[SAMPLE_W-1:0]);
      end else begin
         quot = big ? SAMPLE_W'(Q_LIM - 1'b1) : q_ff[SAMPLE_W-1:0];
      end
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

endmodule

// ----- hw/rtl/linear_resampler_core.sv -----
// ---------------------------------------------------------------------------
// linear_resampler_core
// linear interpolation sample rate converter for signed 16-bit mono words
// ---------------------------------------------------------------------------
// results: a word that yields one result sends it from S_FIN; when more follow,
//   each is held until a newer one exists (newest result waits for the run end)
// work: a 19-step serial multiply per input word plus a 17-step restoring divide
//   per result; a new word is taken only in S_IDLE, once the last word's run ends,
//   and an output stall holds the run
// reset: synchronous, active high; rates return to 16000, stream state clears
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_resampler_core_macros.svh"

module linear_resampler_core #(
   parameter int MAX_UPSAMPLE_RATIO = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrs_pkg::SAMPLE_W-1:0]        req_tdata,   // sample_in
   input  logic                                req_tlast,   // stream_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lrs_pkg::SAMPLE_W-1:0]        rsp_tdata,   // sample_out
   output logic [1:0]                          rsp_tuser,   // has_sample, stream_last
   output logic                                rsp_tlast,   // run_last
   input  logic                                csr_we,
   input  lrs_pkg::csr_addr_type               csr_addr,
   input  logic [lrs_pkg::RATE_W-1:0]          csr_wdata
);
   import lrs_pkg::*;

   localparam int CNT_W = $clog2(MAX_UPSAMPLE_RATIO + 1);
   localparam int LIM_W = RATE_W + CNT_W;
   localparam int BIT_W = $clog2(PHASE_W + 1);
   localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_UPSAMPLE_RATIO);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_LOOP, S_DIV, S_PUSH, S_TAIL, S_FIN
   } state_type;

   // configuration
   logic [RATE_W-1:0] src_ff, tgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= RATE_RESET;
         tgt_ff <= RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SOURCE_RATE: src_ff <= csr_wdata;
            REG_TARGET_RATE: tgt_ff <= csr_wdata;
         endcase
      end
   end

   state_type                state_ff, state_in;
   logic [SAMPLE_W-1:0]      cur_ff, cur_in;
   logic                     end_ff, end_in;
   logic                     act_ff, act_in;
   logic [PHASE_W-1:0]       a_ff, a_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic signed [NUM_W-1:0]  acc_n_ff, acc_n_in;
   logic signed [NUM_W-1:0]  acc_s_ff, acc_s_in;
   logic [PHASE_W-1:0]       mt_ff, mt_in;
   logic [PHASE_W-1:0]       ma_ff, ma_in;
   logic [PHASE_W-1:0]       ms_ff, ms_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [SAMPLE_W-1:0]      new_ff, new_in;
   logic                     tail_ff, tail_in;
   logic [SAMPLE_W-1:0]      pend_ff, pend_in;
   logic                     pend_v_ff, pend_v_in;
   logic                     out_v_ff, out_v_in;
   logic [SAMPLE_W-1:0]      out_data_ff, out_data_in;
   logic                     out_has_ff, out_has_in;
   logic                     out_rl_ff, out_rl_in;
   logic                     out_sl_ff, out_sl_in;
   logic [SAMPLE_W-1:0]      prev_ff, prev_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic                     seen_ff, seen_in;
   logic                     div_start_ff, div_start_in;

   logic [LIM_W-1:0]         lim;
   logic                     active;
   logic                     out_free;
   logic                     fin;
   logic [PHASE_W-1:0]       t_x;
   logic signed [NUM_W-1:0]  left_x, diff_x;
   logic signed [SAMPLE_W-1:0] quot;
   div_stat_type             div_stat;

   lrs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (acc_n_ff),
      .den   (tgt_ff),
      .quot  (quot),
      .stat  (div_stat)
   );

   always_comb begin
      lim    = LIM_W'(src_ff) * LIM_W'(MAX_UPSAMPLE_RATIO);
      active = (tgt_ff != '0) && (src_ff != '0) && (LIM_W'(tgt_ff) <= lim);
      t_x    = {1'b0, tgt_ff};
      left_x = {{(NUM_W - SAMPLE_W){prev_ff[SAMPLE_W-1]}}, prev_ff};
      diff_x = {{(NUM_W - SAMPLE_W){cur_ff[SAMPLE_W-1]}}, cur_ff} - left_x;
      out_free = !out_v_ff || rsp_tready;
      fin = 1'b0;

      state_in     = state_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      act_in       = act_ff;
      a_in         = a_ff;
      n_in         = n_ff;
      acc_n_in     = acc_n_ff;
      acc_s_in     = acc_s_ff;
      mt_in        = mt_ff;
      ma_in        = ma_ff;
      ms_in        = ms_ff;
      bit_in       = bit_ff;
      new_in       = new_ff;
      tail_in      = tail_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      out_v_in     = out_v_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_has_in   = out_has_ff;
      out_rl_in    = out_rl_ff;
      out_sl_in    = out_sl_ff;
      prev_in      = prev_ff;
      phase_in     = phase_ff;
      seen_in      = seen_ff;
      div_start_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cur_in    = req_tdata;
               end_in    = req_tlast;
               act_in    = active;
               n_in      = '0;
               pend_v_in = 1'b0;
               tail_in   = 1'b0;
               a_in      = active ? phase_ff : '0;
               if (active && seen_ff) begin
                  mt_in    = t_x;
                  ma_in    = phase_ff;
                  ms_in    = {1'b0, src_ff};
                  acc_n_in = '0;
                  acc_s_in = '0;
                  bit_in   = BIT_W'(PHASE_W);
                  state_in = S_MUL;
               end else begin
                  state_in = S_TAIL;
               end
            end
         end
         // msb-first shift-add: t*left + a*diff and s*diff
         S_MUL: begin
            acc_n_in = {acc_n_ff[NUM_W-2:0], 1'b0}
                       + (mt_ff[PHASE_W-1] ? left_x : '0)
                       + (ma_ff[PHASE_W-1] ? diff_x : '0);
            acc_s_in = {acc_s_ff[NUM_W-2:0], 1'b0}
                       + (ms_ff[PHASE_W-1] ? diff_x : '0);
            mt_in  = {mt_ff[PHASE_W-2:0], 1'b0};
            ma_in  = {ma_ff[PHASE_W-2:0], 1'b0};
            ms_in  = {ms_ff[PHASE_W-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == BIT_W'(1)) begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (a_ff < t_x && n_ff < N_MAX) begin
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end else begin
               a_in     = (a_ff >= t_x) ? a_ff - t_x : '0;
               state_in = S_TAIL;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               new_in   = quot;
               n_in     = n_ff + 1'b1;
               a_in     = a_ff + PHASE_W'(src_ff);
               acc_n_in = acc_n_ff + acc_s_ff;
               state_in = S_PUSH;
            end
         end
         // the held word goes out once a newer one exists
         S_PUSH: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_data_in = pend_ff;
                  out_has_in  = 1'b1;
                  out_rl_in   = 1'b0;
                  out_sl_in   = 1'b0;
               end
               pend_in   = new_ff;
               pend_v_in = 1'b1;
               state_in  = tail_ff ? S_FIN : S_LOOP;
            end
         end
         S_TAIL: begin
            if (act_ff && end_ff && a_ff == '0) begin
               new_in   = cur_ff;
               tail_in  = 1'b1;
               state_in = S_PUSH;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (pend_v_ff || end_ff) begin
               if (out_free) begin
                  out_v_in    = 1'b1;
                  out_data_in = pend_v_ff ? pend_ff : '0;
                  out_has_in  = pend_v_ff;
                  out_rl_in   = 1'b1;
                  out_sl_in   = end_ff;
                  fin         = 1'b1;
               end
            end else begin
               fin = 1'b1;
            end
            if (fin) begin
               pend_v_in = 1'b0;
               prev_in   = end_ff ? '0 : cur_ff;
               phase_in  = end_ff ? '0 : a_ff;
               seen_in   = !end_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      act_ff      <= act_in;
      a_ff        <= a_in;
      n_ff        <= n_in;
      acc_n_ff    <= acc_n_in;
      acc_s_ff    <= acc_s_in;
      mt_ff       <= mt_in;
      ma_ff       <= ma_in;
      ms_ff       <= ms_in;
      bit_ff      <= bit_in;
      new_ff      <= new_in;
      tail_ff     <= tail_in;
      pend_ff     <= pend_in;
      out_data_ff <= out_data_in;
      out_has_ff  <= out_has_in;
      out_rl_ff   <= out_rl_in;
      out_sl_ff   <= out_sl_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
         prev_ff      <= '0;
         phase_ff     <= '0;
         seen_ff      <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_v_ff    <= pend_v_in;
         out_v_ff     <= out_v_in;
         prev_ff      <= prev_in;
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
         div_start_ff <= div_start_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_sl_ff, out_has_ff};
   assign rsp_tlast  = out_rl_ff;

   `LRS_ASSERT_IMPLIES(a_end_only_closes, rsp_tvalid && !rsp_tuser[0], rsp_tlast && rsp_tuser[1])
   `LRS_ASSERT_IMPLIES(a_stream_last_run, rsp_tvalid && rsp_tuser[1], rsp_tlast)
   `LRS_ASSERT_IMPLIES(a_div_done_in_div, div_stat.done, state_ff == S_DIV)
   `LRS_ASSERT_IMPLIES(a_fresh_stream, state_ff == S_IDLE && !seen_ff, phase_ff == '0 && prev_ff == '0)

endmodule
